/* rtl/core/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic [WORD_W-1:0] page;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] radius;
  } spq_entry_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/spq_if.sv */
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] page_id;
  logic [WORD_W-1:0] distance;
  logic [WORD_W-1:0] radius;

  modport source (output valid, kind, page_id, distance, radius, input ready);
  modport sink   (input valid, kind, page_id, distance, radius, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [WORD_W-1:0]  page_id_out;
  logic [WORD_W-1:0]  distance_out;
  logic [WORD_W-1:0]  radius_out;
  logic               dropped;
  logic [COUNT_W-1:0] count;

  modport source (output valid, found, page_id_out, distance_out, radius_out, dropped, count,
                  input ready);
  modport sink   (input valid, found, page_id_out, distance_out, radius_out, dropped, count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/sorted_priority_queue_top.sv */
`default_nettype none

// Channel  Role    Beat contents
// req      sink    kind, page_id, distance, radius
// rsp      source  found, page_id_out, distance_out, radius_out, dropped, count
//
// Every item is resolved in parallel: all cells compare the broadcast key at
// once and shift by one place, so the chain takes an item each cycle while req.ready is high.
// The result sits in an output register in the cycle after the req beat.
// req.ready is low during rst, and while a result waits in that register and rsp.ready is low.
// rst clears the entry count and the result valid; cell contents are not reset.

module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  spq_entry_t          ent [DEPTH];
  logic [DEPTH-1:0]    ge;
  spq_entry_t          new_ent;
  spq_ctl_t            ctl;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic                accept;
  logic                full;
  logic                empty;
  logic                drop;

  assign accept  = req.valid && req.ready;
  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign full    = cnt == CW'(DEPTH);
  assign empty   = cnt == '0;
  assign new_ent = '{page: req.page_id, key: req.distance, radius: req.radius};

  assign ctl.ins = accept && (req.kind == KIND_INSERT) && !full;
  assign ctl.rem = accept && (req.kind == KIND_REMOVE) && !empty;
  assign drop    = accept && (req.kind == KIND_INSERT) && full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left;
    spq_entry_t right;
    logic       left_ge;

    if (i == 0) begin : g_head
      assign left    = new_ent;
      assign left_ge = 1'b0;
    end else begin : g_body
      assign left    = ent[i-1];
      assign left_ge = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = ent[i];
    end else begin : g_mid
      assign right = ent[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .new_ent (new_ent),
      .left    (left),
      .left_ge (left_ge),
      .right   (right),
      .cnt     (cnt),
      .ge      (ge[i]),
      .ent     (ent[i])
    );
  end

  always_comb begin
    cnt_next = cnt;
    if (ctl.ins) begin
      cnt_next = cnt + CW'(1);
    end else if (ctl.rem) begin
      cnt_next = cnt - CW'(1);
    end
  end

  // count field carries the low bits only when DEPTH needs more than 7
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.found        <= ctl.rem;
      rsp.page_id_out  <= ctl.rem ? ent[0].page   : '0;
      rsp.distance_out <= ctl.rem ? ent[0].key    : '0;
      rsp.radius_out   <= ctl.rem ? ent[0].radius : '0;
      rsp.dropped      <= drop;
      rsp.count        <= cnt_ext[COUNT_W-1:0];
    end
  end

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (req.kind == KIND_INSERT) && full |=> rsp.valid && rsp.dropped && full)
    else $error("insert into full queue not dropped");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    accept && (req.kind == KIND_REMOVE) && empty |=> rsp.valid && !rsp.found && empty)
    else $error("remove from empty queue changed state");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    ctl.rem |=> rsp.found && (rsp.distance_out == $past(ent[0].key))
                && (cnt == $past(cnt) - CW'(1)))
    else $error("remove did not return head entry");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cnt))
    else $error("entry count changed without a beat");

  a_never_over: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> cnt <= CW'(DEPTH) && cnt != '0)
    else $error("entry count out of range after insert");

endmodule

`default_nettype wire

/* rtl/core/spq_cell.sv */
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 7
) (
  input  wire logic       clk,
  input  wire spq_ctl_t   ctl,
  input  wire spq_entry_t new_ent,
  input  wire spq_entry_t left,
  input  wire logic       left_ge,
  input  wire spq_entry_t right,
  input  wire logic [CW-1:0] cnt,
  output logic            ge,
  output spq_entry_t      ent
);

  logic occupied;

  // An empty cell acts as +infinity, so the list stays monotonic in ge
  assign occupied = cnt > CW'(INDEX);
  assign ge       = !occupied || (ent.key >= new_ent.key);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_ge) begin
        ent <= left;
      end else if (ge) begin
        ent <= new_ent;
      end
    end else if (ctl.rem) begin
      ent <= right;
    end
  end

endmodule

`default_nettype wire
